@@ hw/rtl/mbe_pkg.sv @@
// Package for the escape-time evaluator: field widths, item structs,
// register indexes, reset values and the multiplier shift select.
// No dependencies.
package mbe_pkg;

   localparam int COORD_W    = 32;
   localparam int Z_W        = 64;
   localparam int ITER_W     = 16;
   localparam int PERIOD_W   = 11;
   localparam int SCALED_W   = 17;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] REG_ITER_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD_LEN = 1'd1;

   localparam logic [ITER_W-1:0]   ITER_LIMIT_RST = 16'd1024;
   localparam logic [PERIOD_W-1:0] PERIOD_LEN_RST = 11'd20;
   localparam logic [SCALED_W-1:0] SCALED_FULL    = 17'h10000;

   localparam logic signed [Z_W-1:0] Z_MAX = {1'b0, {(Z_W-1){1'b1}}};
   localparam logic signed [Z_W-1:0] Z_MIN = {1'b1, {(Z_W-1){1'b0}}};

   typedef struct packed {
      logic signed [COORD_W-1:0] c_real;
      logic signed [COORD_W-1:0] c_imag;
   } req_type;

   typedef struct packed {
      logic [ITER_W-1:0]   iterations_done;
      logic                not_escaped;
      logic [SCALED_W-1:0] scaled_value;
   } rsp_type;

   // product scaling: frac bits, frac bits - 1 (2xy), frac bits + 2 (y^2/4)
   typedef enum logic [1:0] {
      SH_NORM,
      SH_DBL,
      SH_QTR
   } shift_sel_type;

endpackage

@@ hw/rtl/mbe_mul.sv @@
// Shared 64x64 signed fixed-point multiplier built on one 32x32 unit.
// Four partial products accumulate into a 128-bit register, then floor-shift
// and saturate. Depends on mbe_pkg.
module mbe_mul
   import mbe_pkg::*;
#(
   parameter int FRAC_BITS = 28
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [Z_W-1:0] op_a,
   input  logic signed [Z_W-1:0] op_b,
   input  shift_sel_type         shift_sel,
   output logic                  done,
   output logic signed [Z_W-1:0] result
);

   localparam int HalfW  = Z_W / 2;
   localparam int ProdW  = 2 * Z_W;
   localparam int ShNorm = FRAC_BITS;
   localparam int ShDbl  = FRAC_BITS - 1;
   localparam int ShQtr  = FRAC_BITS + 2;
   localparam logic [ProdW-1:0] MaskNorm = (ProdW'(1) << ShNorm) - ProdW'(1);
   localparam logic [ProdW-1:0] MaskDbl  = (ProdW'(1) << ShDbl) - ProdW'(1);
   localparam logic [ProdW-1:0] MaskQtr  = (ProdW'(1) << ShQtr) - ProdW'(1);
   localparam logic [2:0] StepPpLast = 3'd3;
   localparam logic [2:0] StepFinal  = 3'd5;

   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [2:0]            step_ff, step_in;
   logic [Z_W-1:0]        mag_a_ff, mag_a_in;
   logic [Z_W-1:0]        mag_b_ff, mag_b_in;
   logic                  neg_ff, neg_in;
   shift_sel_type         sel_ff, sel_in;
   logic [Z_W-1:0]        pp_ff, pp_in;
   logic [1:0]            pp_step_ff, pp_step_in;
   logic                  pp_vld_ff, pp_vld_in;
   logic [ProdW-1:0]      acc_ff, acc_in;
   logic signed [Z_W-1:0] result_ff, result_in;

   logic [HalfW-1:0] half_a, half_b;
   logic [ProdW-1:0] addend, shr;
   logic             rem_nz, over;
   logic [Z_W-1:0]   q;
   logic [Z_W:0]     q_up;

   assign half_a = step_ff[1] ? mag_a_ff[Z_W-1:HalfW] : mag_a_ff[HalfW-1:0];
   assign half_b = step_ff[0] ? mag_b_ff[Z_W-1:HalfW] : mag_b_ff[HalfW-1:0];

   always_comb begin
      case (pp_step_ff)
         2'd0:       addend = {{Z_W{1'b0}}, pp_ff};
         2'd1, 2'd2: addend = {{Z_W{1'b0}}, pp_ff} << HalfW;
         default:    addend = {{Z_W{1'b0}}, pp_ff} << Z_W;
      endcase
   end

   // floor shift of the magnitude product, remainder flag for negative results
   always_comb begin
      case (sel_ff)
         SH_DBL: begin
            shr    = acc_ff >> ShDbl;
            rem_nz = |(acc_ff & MaskDbl);
         end
         SH_QTR: begin
            shr    = acc_ff >> ShQtr;
            rem_nz = |(acc_ff & MaskQtr);
         end
         default: begin
            shr    = acc_ff >> ShNorm;
            rem_nz = |(acc_ff & MaskNorm);
         end
      endcase
      over = |shr[ProdW-1:Z_W];
      q    = shr[Z_W-1:0];
      q_up = {1'b0, q} + {{Z_W{1'b0}}, rem_nz};
   end

   always_comb begin
      run_in     = run_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      mag_a_in   = mag_a_ff;
      mag_b_in   = mag_b_ff;
      neg_in     = neg_ff;
      sel_in     = sel_ff;
      pp_in      = pp_ff;
      pp_step_in = pp_step_ff;
      pp_vld_in  = 1'b0;
      acc_in     = acc_ff;
      result_in  = result_ff;
      if (!run_ff) begin
         if (start) begin
            run_in   = 1'b1;
            step_in  = '0;
            mag_a_in = op_a[Z_W-1] ? (Z_W'(0) - op_a) : op_a;
            mag_b_in = op_b[Z_W-1] ? (Z_W'(0) - op_b) : op_b;
            neg_in   = op_a[Z_W-1] ^ op_b[Z_W-1];
            sel_in   = shift_sel;
            acc_in   = '0;
         end
      end else begin
         step_in = step_ff + 3'd1;
         if (step_ff <= StepPpLast) begin
            pp_in      = Z_W'(half_a) * Z_W'(half_b);
            pp_step_in = step_ff[1:0];
            pp_vld_in  = 1'b1;
         end
         if (pp_vld_ff) begin
            acc_in = acc_ff + addend;
         end
         if (step_ff == StepFinal) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            if (!neg_ff) begin
               result_in = (over || q[Z_W-1]) ? Z_MAX : q;
            end else if (over || q_up[Z_W] || q_up[Z_W-1]) begin
               result_in = Z_MIN;
            end else begin
               result_in = Z_W'(0) - q_up[Z_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
         pp_vld_ff <= 1'b0;
      end else begin
         run_ff    <= run_in;
         done_ff   <= done_in;
         step_ff   <= step_in;
         pp_vld_ff <= pp_vld_in;
      end
      mag_a_ff   <= mag_a_in;
      mag_b_ff   <= mag_b_in;
      neg_ff     <= neg_in;
      sel_ff     <= sel_in;
      pp_ff      <= pp_in;
      pp_step_ff <= pp_step_in;
      acc_ff     <= acc_in;
      result_ff  <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

@@ hw/rtl/mbe_div.sv @@
// Bit-serial fraction divider: floor(numer * 2^16 / denom) for numer < denom.
// One quotient bit per cycle. Depends on mbe_pkg.
module mbe_div
   import mbe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [ITER_W-1:0] numer,
   input  logic [ITER_W-1:0] denom,
   output logic              done,
   output logic [ITER_W-1:0] quot
);

   localparam int CntW = $clog2(ITER_W);
   localparam logic [CntW-1:0] CntLast = CntW'(ITER_W - 1);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [ITER_W-1:0] rem_ff, rem_in;
   logic [ITER_W-1:0] quot_ff, quot_in;

   logic [ITER_W:0] trial, diff;
   logic            fits;

   assign trial = {rem_ff, 1'b0};
   assign diff  = trial - {1'b0, denom};
   assign fits  = trial >= {1'b0, denom};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (!run_ff) begin
         if (start) begin
            run_in = 1'b1;
            cnt_in = '0;
            rem_in = numer;
         end
      end else begin
         rem_in  = fits ? diff[ITER_W-1:0] : trial[ITER_W-1:0];
         quot_in = {quot_ff[ITER_W-2:0], fits};
         cnt_in  = cnt_ff + CntW'(1);
         if (cnt_ff == CntLast) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

@@ hw/rtl/mandelbrot_escape_time.sv @@
// Top level of the escape-time evaluator: sequencer, config registers, result register.
// Instantiates mbe_mul (shared multiplier) and mbe_div (scaling divider).
// Depends on mbe_pkg.
//
//  channel   ports                          handshake
//  --------  -----------------------------  ------------------------------------
//  input     start, busy, req_data          item taken when start & !busy
//  result    rsp_valid, rsp_data            one-cycle strobe, always taken
//  config    csr_we, csr_index, csr_wdata   written on any edge with csr_we
//
// Sequence: one 32x32 multiplier does each 64x64 product. A strobe ends each taken
// item: for a cardioid/bulb point, when the limit N is reached, for a repeat found at
// iteration N, and for an escape after N iterations (last square pass plus divider).
// Reset: synchronous, clears the sequencer and loads the register defaults.
// No stalls: a result shows for one cycle and busy is already low in that cycle.
module mandelbrot_escape_time
   import mbe_pkg::*;
#(
   parameter int COORD_FRAC_BITS = 28
) (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   // results
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   // config
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // fixed-point constants at the chosen fraction width
   localparam logic signed [Z_W-1:0] FxOne     = Z_W'(1) <<< COORD_FRAC_BITS;
   localparam logic signed [Z_W-1:0] FourFx    = FxOne <<< 2;
   localparam logic signed [Z_W-1:0] Quarter   = FxOne >>> 2;
   localparam logic signed [Z_W-1:0] Sixteenth = FxOne >>> 4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_C_Y2,    // y^2
      ST_C_RHS,   // y^2 / 4
      ST_C_XM,    // (x - 1/4)^2, then q
      ST_C_QS,    // q + (x - 1/4)
      ST_C_LHS,   // q * (q + x - 1/4)
      ST_C_B,     // (x + 1)^2 + y^2, final region decision
      ST_I_TOP,   // iteration limit check
      ST_I_X2,    // zr^2
      ST_I_Y2,    // zi^2
      ST_I_XY,    // 2 zr zi, escape test runs meanwhile
      ST_I_CMP,   // period compare and history save
      ST_DIV
   } state_type;

   function automatic logic signed [Z_W-1:0] sat_add(input logic signed [Z_W-1:0] a,
                                                     input logic signed [Z_W-1:0] b);
      logic signed [Z_W:0] s;
      s = {a[Z_W-1], a} + {b[Z_W-1], b};
      if (s[Z_W] != s[Z_W-1]) begin
         sat_add = s[Z_W] ? Z_MIN : Z_MAX;
      end else begin
         sat_add = s[Z_W-1:0];
      end
   endfunction

   function automatic logic signed [Z_W-1:0] clamp4(input logic signed [Z_W-1:0] v);
      if (v > FourFx) begin
         clamp4 = FourFx;
      end else if (v < -FourFx) begin
         clamp4 = -FourFx;
      end else begin
         clamp4 = v;
      end
   endfunction

   state_type             state_ff, state_in;
   logic signed [Z_W-1:0] cr_ff, cr_in, ci_ff, ci_in;
   logic signed [Z_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0] zr_ff, zr_in, zi_ff, zi_in;
   logic signed [Z_W-1:0] hr_ff, hr_in, hi_ff, hi_in;
   logic signed [Z_W-1:0] x2_ff, x2_in, y2_ff, y2_in;
   logic signed [Z_W-1:0] rhs_ff, rhs_in, q_ff, q_in, nr1_ff, nr1_in;
   logic                  esc_ff, esc_in, inside_ff, inside_in;
   logic [ITER_W-1:0]     count_ff, count_in;
   logic [PERIOD_W-1:0]   phase_ff, phase_in;
   logic                  mul_go_ff, mul_go_in;
   logic signed [Z_W-1:0] mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   shift_sel_type         mul_sel_ff, mul_sel_in;
   logic                  div_go_ff, div_go_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic [ITER_W-1:0]     iter_limit_ff, iter_limit_in;
   logic [PERIOD_W-1:0]   period_len_ff, period_len_in;

   logic                  mul_done, div_done;
   logic signed [Z_W-1:0] mul_res;
   logic [ITER_W-1:0]     div_quot;

   logic signed [Z_W-1:0] c_r_ext, c_i_ext, c_r_clamp, c_i_clamp;
   logic signed [Z_W-1:0] xm, xp;
   logic [PERIOD_W-1:0]   period_eff;
   logic [PERIOD_W:0]     phase_next;

   assign c_r_ext   = {{(Z_W-COORD_W){req_data.c_real[COORD_W-1]}}, req_data.c_real};
   assign c_i_ext   = {{(Z_W-COORD_W){req_data.c_imag[COORD_W-1]}}, req_data.c_imag};
   assign c_r_clamp = clamp4(c_r_ext);
   assign c_i_clamp = clamp4(c_i_ext);
   assign xm        = x_ff - Quarter;
   assign xp        = x_ff + FxOne;
   // a period length of zero behaves as one: history saved every iteration
   assign period_eff = (period_len_ff == '0) ? PERIOD_W'(1) : period_len_ff;
   assign phase_next = {1'b0, phase_ff} + (PERIOD_W+1)'(1);

   mbe_mul #(
      .FRAC_BITS (COORD_FRAC_BITS)
   ) u_mul (
      .clock     (clock),
      .reset     (reset),
      .start     (mul_go_ff),
      .op_a      (mul_a_ff),
      .op_b      (mul_b_ff),
      .shift_sel (mul_sel_ff),
      .done      (mul_done),
      .result    (mul_res)
   );

   mbe_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go_ff),
      .numer (count_ff),
      .denom (iter_limit_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in      = state_ff;
      cr_in         = cr_ff;
      ci_in         = ci_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      zr_in         = zr_ff;
      zi_in         = zi_ff;
      hr_in         = hr_ff;
      hi_in         = hi_ff;
      x2_in         = x2_ff;
      y2_in         = y2_ff;
      rhs_in        = rhs_ff;
      q_in          = q_ff;
      nr1_in        = nr1_ff;
      esc_in        = esc_ff;
      inside_in     = inside_ff;
      count_in      = count_ff;
      phase_in      = phase_ff;
      mul_go_in     = 1'b0;
      mul_a_in      = mul_a_ff;
      mul_b_in      = mul_b_ff;
      mul_sel_in    = mul_sel_ff;
      div_go_in     = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      iter_limit_in = iter_limit_ff;
      period_len_in = period_len_ff;

      if (csr_we) begin
         case (csr_index)
            REG_ITER_LIMIT: iter_limit_in = csr_wdata[ITER_W-1:0];
            REG_PERIOD_LEN: period_len_in = csr_wdata[PERIOD_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cr_in      = c_r_ext;
               ci_in      = c_i_ext;
               x_in       = c_r_clamp;
               y_in       = c_i_clamp;
               zr_in      = c_r_ext;
               zi_in      = c_i_ext;
               hr_in      = '0;
               hi_in      = '0;
               count_in   = '0;
               phase_in   = '0;
               mul_a_in   = c_i_clamp;
               mul_b_in   = c_i_clamp;
               mul_sel_in = SH_NORM;
               mul_go_in  = 1'b1;
               state_in   = ST_C_Y2;
            end
         end
         ST_C_Y2: begin
            if (mul_done) begin
               y2_in      = mul_res;
               mul_a_in   = y_ff;
               mul_b_in   = y_ff;
               mul_sel_in = SH_QTR;
               mul_go_in  = 1'b1;
               state_in   = ST_C_RHS;
            end
         end
         ST_C_RHS: begin
            if (mul_done) begin
               rhs_in     = mul_res;
               mul_a_in   = xm;
               mul_b_in   = xm;
               mul_sel_in = SH_NORM;
               mul_go_in  = 1'b1;
               state_in   = ST_C_XM;
            end
         end
         ST_C_XM: begin
            if (mul_done) begin
               q_in     = sat_add(mul_res, y2_ff);
               state_in = ST_C_QS;
            end
         end
         ST_C_QS: begin
            mul_a_in   = q_ff;
            mul_b_in   = sat_add(q_ff, xm);
            mul_sel_in = SH_NORM;
            mul_go_in  = 1'b1;
            state_in   = ST_C_LHS;
         end
         ST_C_LHS: begin
            if (mul_done) begin
               inside_in  = (mul_res <= rhs_ff);
               mul_a_in   = xp;
               mul_b_in   = xp;
               mul_sel_in = SH_NORM;
               mul_go_in  = 1'b1;
               state_in   = ST_C_B;
            end
         end
         ST_C_B: begin
            if (mul_done) begin
               // main cardioid or period-2 bulb: done without iterating
               if (inside_ff || (sat_add(mul_res, y2_ff) <= Sixteenth)) begin
                  rsp_valid_in                = 1'b1;
                  rsp_data_in.iterations_done = '0;
                  rsp_data_in.not_escaped     = 1'b1;
                  rsp_data_in.scaled_value    = SCALED_FULL;
                  state_in                    = ST_IDLE;
               end else begin
                  state_in = ST_I_TOP;
               end
            end
         end
         ST_I_TOP: begin
            if (count_ff >= iter_limit_ff) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.iterations_done = count_ff;
               rsp_data_in.not_escaped     = 1'b1;
               rsp_data_in.scaled_value    = SCALED_FULL;
               state_in                    = ST_IDLE;
            end else begin
               mul_a_in   = zr_ff;
               mul_b_in   = zr_ff;
               mul_sel_in = SH_NORM;
               mul_go_in  = 1'b1;
               state_in   = ST_I_X2;
            end
         end
         ST_I_X2: begin
            if (mul_done) begin
               x2_in      = mul_res;
               mul_a_in   = zi_ff;
               mul_b_in   = zi_ff;
               mul_sel_in = SH_NORM;
               mul_go_in  = 1'b1;
               state_in   = ST_I_Y2;
            end
         end
         ST_I_Y2: begin
            if (mul_done) begin
               y2_in      = mul_res;
               mul_a_in   = zr_ff;
               mul_b_in   = zi_ff;
               mul_sel_in = SH_DBL;
               mul_go_in  = 1'b1;
               state_in   = ST_I_XY;
            end
         end
         ST_I_XY: begin
            // squares are stable here; escape test and x^2 - y^2 settle early
            esc_in = (sat_add(x2_ff, y2_ff) >= FourFx);
            nr1_in = sat_add(x2_ff, -y2_ff);
            if (mul_done) begin
               if (esc_ff) begin
                  div_go_in = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  zr_in    = sat_add(nr1_ff, cr_ff);
                  zi_in    = sat_add(mul_res, ci_ff);
                  state_in = ST_I_CMP;
               end
            end
         end
         ST_I_CMP: begin
            if (zr_ff == hr_ff && zi_ff == hi_ff) begin
               // exact repeat of the saved z: periodic orbit
               rsp_valid_in                = 1'b1;
               rsp_data_in.iterations_done = count_ff + ITER_W'(1);
               rsp_data_in.not_escaped     = 1'b1;
               rsp_data_in.scaled_value    = SCALED_FULL;
               state_in                    = ST_IDLE;
            end else begin
               if (phase_ff == '0) begin
                  hr_in = zr_ff;
                  hi_in = zi_ff;
               end
               phase_in = (phase_next == {1'b0, period_eff}) ? '0 : phase_next[PERIOD_W-1:0];
               count_in = count_ff + ITER_W'(1);
               state_in = ST_I_TOP;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.iterations_done = count_ff;
               rsp_data_in.not_escaped     = 1'b0;
               rsp_data_in.scaled_value    = {1'b0, div_quot};
               state_in                    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mul_go_ff     <= 1'b0;
         div_go_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         iter_limit_ff <= ITER_LIMIT_RST;
         period_len_ff <= PERIOD_LEN_RST;
      end else begin
         state_ff      <= state_in;
         mul_go_ff     <= mul_go_in;
         div_go_ff     <= div_go_in;
         rsp_valid_ff  <= rsp_valid_in;
         iter_limit_ff <= iter_limit_in;
         period_len_ff <= period_len_in;
      end
      cr_ff       <= cr_in;
      ci_ff       <= ci_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      zr_ff       <= zr_in;
      zi_ff       <= zi_in;
      hr_ff       <= hr_in;
      hi_ff       <= hi_in;
      x2_ff       <= x2_in;
      y2_ff       <= y2_in;
      rhs_ff      <= rhs_in;
      q_ff        <= q_in;
      nr1_ff      <= nr1_in;
      esc_ff      <= esc_in;
      inside_ff   <= inside_in;
      count_ff    <= count_in;
      phase_ff    <= phase_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      mul_sel_ff  <= mul_sel_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // a taken item keeps the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item taken but block not busy");

   // a result only comes out of a running item
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without an item in flight");

   // non-escaped points always report the full scale value
   a_full_scale: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.not_escaped) |-> (rsp_data.scaled_value == SCALED_FULL))
      else $error("not-escaped result with partial scale");
`endif

endmodule
